>>> sv/gcrap_pkg.sv
`default_nettype none
package gcrap_pkg;

	// field widths of the stream beats
	localparam int TENANT_W   = 6;
	localparam int ARRIVAL_W  = 48;
	localparam int LEVEL_W    = 32;
	localparam int RATE_W     = 32;
	localparam int LIMIT_W    = 31;
	localparam int INC_W      = 16;
	localparam int DRAIN_W    = 33;
	localparam int S_TDATA_W  = 56;
	localparam int M_TDATA_W  = 40;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DRAIN_RATE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BURST_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PACKET_INC  = 2'd2;

	// configuration reset values
	localparam logic [RATE_W-1:0]  DRAIN_RATE_RST  = 32'd65536;
	localparam logic [LIMIT_W-1:0] BURST_LIMIT_RST = 31'd12000;
	localparam logic [INC_W-1:0]   PACKET_INC_RST  = 16'd1500;

	// verdict codes
	localparam logic VERDICT_PASS = 1'b0;
	localparam logic VERDICT_DROP = 1'b1;

	// drained amount cap: empties any level
	localparam logic [DRAIN_W-1:0] DRAIN_CAP = 33'h1_0000_0000;

	// load strobes for the drain unit's pipeline registers
	typedef struct packed {
		logic s3;
		logic s4;
	} drain_ld_t;

endpackage
`default_nettype wire

>>> sv/per_tenant_gcra_policer_core.sv
`default_nettype none
// Per-tenant GCRA policer. Each s_tdata beat is a packet arrival (tenant and ns timestamp);
// each m_tdata beat is its verdict and the tenant's bucket level after it. Tenant state
// (level and last accept time) lives in one RAM that is read at accept and written back
// five stages later, so the block judges one packet per cycle while s_tready is not held
// low by back-pressure, the sweep or a tenant hazard; m_tvalid is driven by an output
// register behind stage five. A packet whose tenant still has an earlier packet in those
// five stages waits until that write-back is done. After reset the RAM is swept to zero,
// during which s_tready stays low; configuration writes are taken at any time and must only
// happen while no packet is in flight.
module per_tenant_gcra_policer_core #(
	parameter int TENANT_COUNT = 64,
	parameter int TIME_BITS    = 48
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// [5:0] tenant_id, [53:6] arrival_time, [55:54] zero
	input  wire logic [gcrap_pkg::S_TDATA_W-1:0]     s_tdata,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// [5:0] tenant_out, [6] verdict, [38:7] level_after, [39] zero
	output logic      [gcrap_pkg::M_TDATA_W-1:0]     m_tdata,
	input  wire logic                                cfg_we,
	input  wire logic [gcrap_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [gcrap_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int IDX_W = (TENANT_COUNT > 1) ? $clog2(TENANT_COUNT) : 1;
	localparam int MEM_W = gcrap_pkg::LEVEL_W + TIME_BITS;
	localparam int TW    = gcrap_pkg::TENANT_W;
	localparam int LW    = gcrap_pkg::LEVEL_W;

	// configuration registers
	logic [gcrap_pkg::RATE_W-1:0]  drain_rate_q;
	logic [gcrap_pkg::LIMIT_W-1:0] burst_limit_q;
	logic [gcrap_pkg::INC_W-1:0]   packet_inc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_rate_q  <= gcrap_pkg::DRAIN_RATE_RST;
			burst_limit_q <= gcrap_pkg::BURST_LIMIT_RST;
			packet_inc_q  <= gcrap_pkg::PACKET_INC_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gcrap_pkg::REG_DRAIN_RATE:  drain_rate_q  <= cfg_data;
				gcrap_pkg::REG_BURST_LIMIT: burst_limit_q <= cfg_data[gcrap_pkg::LIMIT_W-1:0];
				gcrap_pkg::REG_PACKET_INC:  packet_inc_q  <= cfg_data[gcrap_pkg::INC_W-1:0];
				default: ;
			endcase
		end
	end

	// input beat fields
	logic [TW-1:0]        in_tenant;
	logic [TIME_BITS-1:0] in_now;
	logic                 in_oor;
	assign in_tenant = s_tdata[TW-1:0];
	assign in_now    = TIME_BITS'(s_tdata[TW +: gcrap_pkg::ARRIVAL_W]);
	assign in_oor    = 32'(in_tenant) >= 32'(TENANT_COUNT);

	// stage valids and handshake chain
	logic v1_q, v2_q, v3_q, v4_q, v5_q, out_v_q;
	logic rdy_out, rdy1, rdy2, rdy3, rdy4, rdy5;
	logic adv1, adv2, adv3, adv4, adv5;
	logic accept, hazard, clr_busy;
	logic [IDX_W-1:0] clr_addr;

	logic [TW-1:0] tenant_s1, tenant_s2, tenant_s3, tenant_s4, tenant_s5;

	assign rdy_out = !out_v_q || m_tready;
	assign rdy5    = !v5_q || rdy_out;
	assign rdy4    = !v4_q || rdy5;
	assign rdy3    = !v3_q || rdy4;
	assign rdy2    = !v2_q || rdy3;
	assign rdy1    = !v1_q || rdy2;
	assign adv5    = v5_q && rdy_out;
	assign adv4    = v4_q && rdy5;
	assign adv3    = v3_q && rdy4;
	assign adv2    = v2_q && rdy3;
	assign adv1    = v1_q && rdy2;

	// hold a tenant back while its earlier packet has not written back
	assign hazard = (v1_q && tenant_s1 == in_tenant) || (v2_q && tenant_s2 == in_tenant) ||
		(v3_q && tenant_s3 == in_tenant) || (v4_q && tenant_s4 == in_tenant) ||
		(v5_q && tenant_s5 == in_tenant);

	assign s_tready = !clr_busy && rdy1 && !hazard;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q    <= 1'b0;
			v2_q    <= 1'b0;
			v3_q    <= 1'b0;
			v4_q    <= 1'b0;
			v5_q    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			v1_q    <= accept ? 1'b1 : (adv1 ? 1'b0 : v1_q);
			v2_q    <= adv1 ? 1'b1 : (adv2 ? 1'b0 : v2_q);
			v3_q    <= adv2 ? 1'b1 : (adv3 ? 1'b0 : v3_q);
			v4_q    <= adv3 ? 1'b1 : (adv4 ? 1'b0 : v4_q);
			v5_q    <= adv4 ? 1'b1 : (adv5 ? 1'b0 : v5_q);
			out_v_q <= adv5 ? 1'b1 : (m_tready ? 1'b0 : out_v_q);
		end
	end

	// state memory and its reset sweep
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [MEM_W-1:0] ram_wdata;
	logic [MEM_W-1:0] ram_rdata;
	logic             item_we;
	logic [LW-1:0]    next_level;

	gcrap_clear #(.DEPTH(TENANT_COUNT)) u_clear (
		.clk    (clk),
		.arst_n (arst_n),
		.busy   (clr_busy),
		.addr   (clr_addr)
	);

	gcrap_ram #(.WIDTH(MEM_W), .DEPTH(TENANT_COUNT)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (IDX_W'(in_tenant)),
		.rdata (ram_rdata)
	);

	// stage 1: entry arrives from memory, take the elapsed time
	logic [TIME_BITS-1:0] now_s1, now_s2, now_s3, now_s4, now_s5;
	logic                 oor_s1, oor_s2, oor_s3, oor_s4, oor_s5;
	logic [LW-1:0]        level_s2, level_s3, level_s4, level_s5;
	logic [TIME_BITS-1:0] elapsed_s2;
	logic [TIME_BITS:0]   diff;

	always_ff @(posedge clk) begin
		if (accept) begin
			tenant_s1 <= in_tenant;
			now_s1    <= in_now;
			oor_s1    <= in_oor;
		end
	end

	assign diff = {1'b0, now_s1} - {1'b0, ram_rdata[TIME_BITS-1:0]};

	always_ff @(posedge clk) begin
		if (adv1) begin
			tenant_s2  <= tenant_s1;
			now_s2     <= now_s1;
			oor_s2     <= oor_s1;
			level_s2   <= ram_rdata[TIME_BITS +: LW];
			elapsed_s2 <= diff[TIME_BITS] ? '0 : diff[TIME_BITS-1:0];
		end
	end

	// stages 2 and 3: drained amount
	gcrap_pkg::drain_ld_t           drain_ld;
	logic [gcrap_pkg::DRAIN_W-1:0]  drain_s4;

	assign drain_ld.s3 = adv2;
	assign drain_ld.s4 = adv3;

	gcrap_drain #(.TIME_BITS(TIME_BITS)) u_drain (
		.clk        (clk),
		.ld         (drain_ld),
		.elapsed_s2 (elapsed_s2),
		.rate       (drain_rate_q),
		.drain_s4   (drain_s4)
	);

	always_ff @(posedge clk) begin
		if (adv2) begin
			tenant_s3 <= tenant_s2;
			now_s3    <= now_s2;
			oor_s3    <= oor_s2;
			level_s3  <= level_s2;
		end
		if (adv3) begin
			tenant_s4 <= tenant_s3;
			now_s4    <= now_s3;
			oor_s4    <= oor_s3;
			level_s4  <= level_s3;
		end
	end

	// stage 4: tentative level, signed
	logic [LW+1:0] tent_s5;

	always_ff @(posedge clk) begin
		if (adv4) begin
			tenant_s5 <= tenant_s4;
			now_s5    <= now_s4;
			oor_s5    <= oor_s4;
			level_s5  <= level_s4;
			tent_s5   <= {2'b00, level_s4} - {1'b0, drain_s4};
		end
	end

	// stage 5: judge, write back, load the output register
	logic          tent_neg;
	logic          over_limit;
	logic          drop;
	logic [LW-1:0] floor_level;
	logic [LW:0]   inc_sum;

	assign tent_neg    = tent_s5[LW+1];
	assign over_limit  = !tent_neg && (tent_s5[LW:0] > (LW+1)'(burst_limit_q));
	assign drop        = oor_s5 || over_limit;
	assign floor_level = tent_neg ? '0 : tent_s5[LW-1:0];
	assign inc_sum     = {1'b0, floor_level} + (LW+1)'(packet_inc_q);
	assign next_level  = inc_sum[LW] ? '1 : inc_sum[LW-1:0];

	assign item_we   = adv5 && !drop;
	assign ram_we    = clr_busy || item_we;
	assign ram_waddr = clr_busy ? clr_addr : IDX_W'(tenant_s5);
	assign ram_wdata = clr_busy ? '0 : {next_level, now_s5};

	logic [TW-1:0] out_tenant_q;
	logic          out_verdict_q;
	logic [LW-1:0] out_level_q;

	always_ff @(posedge clk) begin
		if (adv5) begin
			out_tenant_q  <= tenant_s5;
			out_verdict_q <= drop ? gcrap_pkg::VERDICT_DROP : gcrap_pkg::VERDICT_PASS;
			if (oor_s5) begin
				out_level_q <= '0;
			end else if (over_limit) begin
				out_level_q <= level_s5;
			end else begin
				out_level_q <= next_level;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {1'b0, out_level_q, out_verdict_q, out_tenant_q};

	// the sweep owns the write port alone
	assert property (@(posedge clk) disable iff (!arst_n) clr_busy |-> !item_we)
		else $error("packet write-back during reset sweep");

	// a written-back level shows up as an accepted beat for the same tenant
	assert property (@(posedge clk) disable iff (!arst_n)
		item_we |=> m_tvalid && out_verdict_q == gcrap_pkg::VERDICT_PASS &&
			out_level_q == $past(next_level) && out_tenant_q == $past(tenant_s5))
		else $error("write-back and output beat disagree");

	// a tenant beyond the table is always dropped with an empty level
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && 32'(out_tenant_q) >= 32'(TENANT_COUNT) |->
			out_verdict_q == gcrap_pkg::VERDICT_DROP && out_level_q == '0)
		else $error("out-of-range tenant not dropped");

endmodule
`default_nettype wire

>>> sv/gcrap_ram.sv
`default_nettype none
module gcrap_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, held between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> sv/gcrap_clear.sv
`default_nettype none
module gcrap_clear #(
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	output logic               busy,
	output logic      [AW-1:0] addr
);

	logic          busy_q;
	logic [AW-1:0] idx_q;

	// sweep every entry once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q) begin
			if (idx_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + AW'(1);
			end
		end
	end

	assign busy = busy_q;
	assign addr = idx_q;

endmodule
`default_nettype wire

>>> sv/gcrap_drain.sv
`default_nettype none
module gcrap_drain #(
	parameter int TIME_BITS = 48
) (
	input  wire logic                           clk,
	input  wire gcrap_pkg::drain_ld_t           ld,
	input  wire logic [TIME_BITS-1:0]           elapsed_s2,
	input  wire logic [gcrap_pkg::RATE_W-1:0]   rate,
	output logic      [gcrap_pkg::DRAIN_W-1:0]  drain_s4
);

	logic [63:0] elapsed64;
	logic [63:0] p_lo;
	logic [63:0] p_hi;
	logic [63:0] p_lo_s3;
	logic [15:0] p_hi16_s3;
	logic        hi_cap_s3;
	logic [48:0] sum;
	logic        cap;

	// split the elapsed time into two 32-bit halves, one product each
	assign elapsed64 = 64'(elapsed_s2);
	assign p_lo      = elapsed64[31:0] * rate;
	assign p_hi      = elapsed64[63:32] * rate;

	always_ff @(posedge clk) begin
		if (ld.s3) begin
			p_lo_s3   <= p_lo;
			p_hi16_s3 <= p_hi[15:0];
			hi_cap_s3 <= |p_hi[63:16];
		end
	end

	// combine the halves, drop the fraction, hold at the cap
	assign sum = 49'({p_hi16_s3, 16'h0000}) + 49'(p_lo_s3[63:16]);
	assign cap = hi_cap_s3 || (sum > 49'(gcrap_pkg::DRAIN_CAP));

	always_ff @(posedge clk) begin
		if (ld.s4) begin
			drain_s4 <= cap ? gcrap_pkg::DRAIN_CAP : sum[gcrap_pkg::DRAIN_W-1:0];
		end
	end

endmodule
`default_nettype wire
